>>> src/false_color_key_interpolator_core_macros.svh
// ----------------------------------------------------------------------------
// false color key interpolator assertion macros
// shared assertion wrappers, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef FALSE_COLOR_KEY_INTERPOLATOR_CORE_MACROS_SVH
`define FALSE_COLOR_KEY_INTERPOLATOR_CORE_MACROS_SVH

// property holds at every clock edge out of reset
`define FCKI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition implies a consequence in the next cycle
`define FCKI_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> src/fcki_pkg.sv
// ----------------------------------------------------------------------------
// fcki_pkg
// types, constants and log2 helpers for the false color key interpolator
// ----------------------------------------------------------------------------
package fcki_pkg;

	localparam int KEY_COUNT       = 5;
	localparam int VALUE_FRAC_BITS = 16;
	localparam int FRAC_W          = 16;
	localparam int LOG_ROUNDS      = 16;
	localparam int M_W             = 34;
	localparam int DD_W            = 33;
	localparam int DR_W            = 34;
	localparam int Q_W             = 17;
	localparam int COLOR_W         = 24;
	localparam int CFG_W           = 64;
	localparam int IDX_W           = 3;
	localparam int KIDX_W          = 3;

	localparam logic [IDX_W-1:0] REG_LOG_MODE  = 3'd0;
	localparam logic [IDX_W-1:0] REG_KEYS_01   = 3'd1;
	localparam logic [IDX_W-1:0] REG_KEYS_23   = 3'd2;
	localparam logic [IDX_W-1:0] REG_KEY_4     = 3'd3;
	localparam logic [IDX_W-1:0] REG_COLORS_01 = 3'd4;
	localparam logic [IDX_W-1:0] REG_COLORS_23 = 3'd5;
	localparam logic [IDX_W-1:0] REG_COLOR_4   = 3'd6;

	// log of zero sits below the log of any nonzero value
	localparam logic signed [M_W-1:0] LOG_ZERO = M_W'(-(VALUE_FRAC_BITS + 1) * 65536);

	typedef enum logic [1:0] {
		KL_IDLE,
		KL_NORM,
		KL_ROUND
	} kl_state_t;

	typedef struct packed {
		logic        zero;
		logic [4:0]  p;
		logic [31:0] mant;
	} log_norm_t;

	typedef struct packed {
		logic        fbit;
		logic [31:0] mant;
	} log_round_t;

	typedef struct packed {
		logic              valid;
		logic [31:0]       v;
		logic              zero;
		logic [4:0]        p;
		logic [31:0]       mant;
		logic [FRAC_W-1:0] frac;
	} lp_stage_t;

	typedef struct packed {
		logic                  valid;
		logic                  err;
		logic signed [M_W-1:0] m;
	} map_t;

	typedef struct packed {
		logic               valid;
		logic               err;
		logic [COLOR_W-1:0] ca;
		logic [COLOR_W-1:0] cb;
		logic [DR_W-1:0]    r;
		logic [DD_W-1:0]    d;
		logic [Q_W-1:0]     q;
	} div_stage_t;

	// msb position and Q1.31 mantissa
	function automatic log_norm_t log_norm(input logic [31:0] v);
		log_norm_t r;
		r.zero = (v == 32'd0);
		r.p = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) r.p = 5'(i);
		end
		r.mant = v << (5'd31 - r.p);
		return r;
	endfunction

	// one squaring round, one fraction bit
	function automatic log_round_t log_round(input logic [31:0] mant);
		logic [63:0] prod;
		log_round_t  r;
		prod = 64'(mant) * 64'(mant);
		r.fbit = prod[63];
		r.mant = prod[63] ? prod[63:32] : prod[62:31];
		return r;
	endfunction

	function automatic logic signed [M_W-1:0] log_value(input logic [4:0] p,
		input logic [FRAC_W-1:0] frac);
		logic signed [M_W-1:0] e;
		e = $signed(M_W'({1'b0, p})) - M_W'(VALUE_FRAC_BITS);
		return (e <<< FRAC_W) + $signed(M_W'(frac));
	endfunction

endpackage

>>> src/false_color_key_interpolator_core.sv
// ----------------------------------------------------------------------------
// false_color_key_interpolator_core
// five key piecewise linear colormap, linear or log2 domain, Q16.16 input
// ----------------------------------------------------------------------------
// one item per cycle while the output is not stalled and the key log unit is idle;
// the log squaring and divider stages are fully pipelined
// after reset and after any key register write the key log unit recomputes
// all five key logs with in_ready low; config writes are always taken
// reset clears valid bits and loads the default keys, colors and log mode
`include "false_color_key_interpolator_core_macros.svh"

module false_color_key_interpolator_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [fcki_pkg::IDX_W-1:0] cfg_index,
	input  logic [fcki_pkg::CFG_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [31:0]                sample_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 red,
	output logic [7:0]                 green,
	output logic [7:0]                 blue,
	output logic                       math_error
);

	logic        log_mode_q;
	logic [63:0] keys01_q;
	logic [63:0] keys23_q;
	logic [31:0] key4_q;
	logic [47:0] colors01_q;
	logic [47:0] colors23_q;
	logic [23:0] color4_q;

	logic adv;
	logic key_busy;
	logic key_restart;
	logic [31:0] kraw [fcki_pkg::KEY_COUNT];
	logic signed [fcki_pkg::M_W-1:0] klog [fcki_pkg::KEY_COUNT];
	logic signed [fcki_pkg::M_W-1:0] kmap [fcki_pkg::KEY_COUNT];
	logic [fcki_pkg::COLOR_W-1:0] col [fcki_pkg::KEY_COUNT];

	fcki_pkg::map_t       map_s;
	fcki_pkg::div_stage_t sel_d, sel_s, div_out;

	logic [fcki_pkg::KIDX_W-1:0] idx;
	logic signed [fcki_pkg::M_W-1:0] n, d;

	logic       out_valid_q;
	logic [7:0] red_q, green_q, blue_q;
	logic       err_q;
	logic [7:0] ch [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_mode_q <= 1'b1;
			keys01_q   <= 64'd89008902248858;
			keys23_q   <= 64'd890101907390464;
			key4_q     <= 32'd655360;
			colors01_q <= 48'd1099494850815;
			colors23_q <= 48'd281470681808640;
			color4_q   <= 24'd16711680;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fcki_pkg::REG_LOG_MODE:  log_mode_q <= cfg_data[0];
				fcki_pkg::REG_KEYS_01:   keys01_q   <= cfg_data;
				fcki_pkg::REG_KEYS_23:   keys23_q   <= cfg_data;
				fcki_pkg::REG_KEY_4:     key4_q     <= cfg_data[31:0];
				fcki_pkg::REG_COLORS_01: colors01_q <= cfg_data[47:0];
				fcki_pkg::REG_COLORS_23: colors23_q <= cfg_data[47:0];
				fcki_pkg::REG_COLOR_4:   color4_q   <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	assign key_restart = cfg_we && (cfg_index == fcki_pkg::REG_KEYS_01
		|| cfg_index == fcki_pkg::REG_KEYS_23 || cfg_index == fcki_pkg::REG_KEY_4);

	always_comb begin
		kraw[0] = keys01_q[31:0];
		kraw[1] = keys01_q[63:32];
		kraw[2] = keys23_q[31:0];
		kraw[3] = keys23_q[63:32];
		kraw[4] = key4_q;
		col[0]  = colors01_q[23:0];
		col[1]  = colors01_q[47:24];
		col[2]  = colors23_q[23:0];
		col[3]  = colors23_q[47:24];
		col[4]  = color4_q;
		for (int j = 0; j < fcki_pkg::KEY_COUNT; j++) begin
			kmap[j] = log_mode_q ? klog[j] : $signed(fcki_pkg::M_W'(kraw[j]));
		end
	end

	fcki_key_log u_key_log (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (key_restart),
		.key_raw (kraw),
		.key_log (klog),
		.busy    (key_busy)
	);

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv && !key_busy;

	fcki_log_pipe u_log_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.accept       (in_valid && in_ready),
		.sample_value (sample_value),
		.lg           (log_mode_q),
		.map_s        (map_s)
	);

	// interval search; clamped ends feed the divider n/d giving t of 0 or 65536
	always_comb begin
		idx = '0;
		n   = '0;
		d   = fcki_pkg::M_W'(1);
		if (map_s.err) begin
			idx = '0;
		end else if (map_s.m <= kmap[0]) begin
			idx = '0;
		end else if (map_s.m >= kmap[fcki_pkg::KEY_COUNT-1]) begin
			idx = fcki_pkg::KIDX_W'(fcki_pkg::KEY_COUNT - 2);
			n   = fcki_pkg::M_W'(1);
		end else begin
			idx = fcki_pkg::KIDX_W'(fcki_pkg::KEY_COUNT - 2);
			for (int j = fcki_pkg::KEY_COUNT - 2; j >= 1; j--) begin
				if (map_s.m <= kmap[j]) idx = fcki_pkg::KIDX_W'(j - 1);
			end
			n = map_s.m - kmap[idx];
			d = kmap[idx + 1'b1] - kmap[idx];
		end
		sel_d.valid = map_s.valid;
		sel_d.err   = map_s.err;
		sel_d.ca    = map_s.err ? '0 : col[idx];
		sel_d.cb    = map_s.err ? '0 : col[idx + 1'b1];
		sel_d.r     = fcki_pkg::DR_W'(n);
		sel_d.d     = fcki_pkg::DD_W'(d);
		sel_d.q     = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_s.valid <= 1'b0;
		end else if (adv) begin
			sel_s <= sel_d;
		end
	end

	fcki_div_pipe u_div_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.din    (sel_s),
		.dout   (div_out)
	);

	// per channel blend, truncating
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			ch[c] = 8'(((25'(div_out.ca[23 - 8*c -: 8])
				* 25'(fcki_pkg::Q_W'(65536) - div_out.q))
				+ (25'(div_out.cb[23 - 8*c -: 8]) * 25'(div_out.q))) >> 16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= div_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_q   <= ch[0];
			green_q <= ch[1];
			blue_q  <= ch[2];
			err_q   <= div_out.err;
		end
	end

	assign out_valid  = out_valid_q;
	assign red        = red_q;
	assign green      = green_q;
	assign blue       = blue_q;
	assign math_error = err_q;

	`FCKI_ASSERT(a_err_black, (!(out_valid && math_error) || (red == 8'd0 && green == 8'd0 && blue == 8'd0)), "math error item is not black")
	`FCKI_ASSERT_NEXT(a_key_write_stall, key_restart, !in_ready, "input taken while key logs recompute")

endmodule

>>> src/fcki_log_pipe.sv
// ----------------------------------------------------------------------------
// fcki_log_pipe
// sample log2 pipeline: normalize, sixteen squaring stages, value mapping
// ----------------------------------------------------------------------------
module fcki_log_pipe (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               accept,
	input  logic [31:0]        sample_value,
	input  logic               lg,
	output fcki_pkg::map_t     map_s
);

	fcki_pkg::lp_stage_t lp_s [fcki_pkg::LOG_ROUNDS+1];
	fcki_pkg::lp_stage_t lp_d [fcki_pkg::LOG_ROUNDS+1];
	fcki_pkg::log_norm_t nrm;
	fcki_pkg::log_round_t rnd [fcki_pkg::LOG_ROUNDS+1];
	logic                            map_valid_s;
	logic                            map_err_s;
	logic signed [fcki_pkg::M_W-1:0] map_m_s;

	always_comb begin
		nrm = fcki_pkg::log_norm(sample_value);
		lp_d[0].valid = accept;
		lp_d[0].v     = sample_value;
		lp_d[0].zero  = nrm.zero;
		lp_d[0].p     = nrm.p;
		lp_d[0].mant  = nrm.mant;
		lp_d[0].frac  = '0;
		rnd[0] = '0;
		for (int k = 1; k <= fcki_pkg::LOG_ROUNDS; k++) begin
			rnd[k] = fcki_pkg::log_round(lp_s[k-1].mant);
			lp_d[k] = lp_s[k-1];
			lp_d[k].mant = rnd[k].mant;
			lp_d[k].frac = {lp_s[k-1].frac[fcki_pkg::FRAC_W-2:0], rnd[k].fbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= fcki_pkg::LOG_ROUNDS; k++) lp_s[k].valid <= 1'b0;
			map_valid_s <= 1'b0;
		end else if (adv) begin
			for (int k = 0; k <= fcki_pkg::LOG_ROUNDS; k++) lp_s[k] <= lp_d[k];
			map_valid_s <= lp_s[fcki_pkg::LOG_ROUNDS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			map_err_s <= lg && lp_s[fcki_pkg::LOG_ROUNDS].zero;
			map_m_s   <= lg ? fcki_pkg::log_value(lp_s[fcki_pkg::LOG_ROUNDS].p,
				lp_s[fcki_pkg::LOG_ROUNDS].frac)
				: $signed(fcki_pkg::M_W'(lp_s[fcki_pkg::LOG_ROUNDS].v));
		end
	end

	assign map_s = '{valid: map_valid_s, err: map_err_s, m: map_m_s};

endmodule

>>> src/fcki_key_log.sv
// ----------------------------------------------------------------------------
// fcki_key_log
// iterative log2 of the five keys, one squaring round per cycle
// ----------------------------------------------------------------------------
module fcki_key_log (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         restart,
	input  logic [31:0]                  key_raw [fcki_pkg::KEY_COUNT],
	output logic signed [fcki_pkg::M_W-1:0] key_log [fcki_pkg::KEY_COUNT],
	output logic                         busy
);

	fcki_pkg::kl_state_t state_q, state_d;
	logic [fcki_pkg::KIDX_W-1:0] key_idx_q;
	logic [3:0]                  round_q;
	logic [31:0]                 mant_q;
	logic [fcki_pkg::FRAC_W-1:0] frac_q;
	logic [4:0]                  p_q;
	logic                        zero_q;
	logic signed [fcki_pkg::M_W-1:0] klog_q [fcki_pkg::KEY_COUNT];
	logic                        last_round;
	logic                        last_key;
	fcki_pkg::log_round_t        rnd;
	fcki_pkg::log_norm_t         nrm;
	logic [fcki_pkg::FRAC_W-1:0] frac_next;

	always_comb begin
		last_round = (round_q == 4'(fcki_pkg::LOG_ROUNDS - 1));
		last_key   = (key_idx_q == fcki_pkg::KIDX_W'(fcki_pkg::KEY_COUNT - 1));
		rnd        = fcki_pkg::log_round(mant_q);
		nrm        = fcki_pkg::log_norm(key_raw[key_idx_q]);
		frac_next  = {frac_q[fcki_pkg::FRAC_W-2:0], rnd.fbit};
		state_d    = state_q;
		unique case (state_q)
			fcki_pkg::KL_IDLE: state_d = fcki_pkg::KL_IDLE;
			fcki_pkg::KL_NORM: state_d = fcki_pkg::KL_ROUND;
			fcki_pkg::KL_ROUND: begin
				if (last_round) state_d = last_key ? fcki_pkg::KL_IDLE : fcki_pkg::KL_NORM;
			end
			default: state_d = fcki_pkg::KL_IDLE;
		endcase
		if (restart) state_d = fcki_pkg::KL_NORM;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fcki_pkg::KL_NORM;
			key_idx_q <= '0;
			round_q   <= '0;
		end else begin
			state_q <= state_d;
			if (restart) begin
				key_idx_q <= '0;
			end else if (state_q == fcki_pkg::KL_ROUND && last_round && !last_key) begin
				key_idx_q <= key_idx_q + 1'b1;
			end
			if (state_q == fcki_pkg::KL_ROUND) round_q <= round_q + 1'b1;
			else round_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fcki_pkg::KL_NORM) begin
			mant_q <= nrm.mant;
			p_q    <= nrm.p;
			zero_q <= nrm.zero;
			frac_q <= '0;
		end else if (state_q == fcki_pkg::KL_ROUND) begin
			mant_q <= rnd.mant;
			frac_q <= frac_next;
			if (last_round) begin
				klog_q[key_idx_q] <= zero_q ? fcki_pkg::LOG_ZERO
					: fcki_pkg::log_value(p_q, frac_next);
			end
		end
	end

	assign key_log = klog_q;
	assign busy    = (state_q != fcki_pkg::KL_IDLE);

endmodule

>>> src/fcki_div_pipe.sv
// ----------------------------------------------------------------------------
// fcki_div_pipe
// restoring divider, one quotient bit per stage, seventeen stages
// ----------------------------------------------------------------------------
`include "false_color_key_interpolator_core_macros.svh"

module fcki_div_pipe (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  fcki_pkg::div_stage_t din,
	output fcki_pkg::div_stage_t dout
);

	fcki_pkg::div_stage_t div_s [fcki_pkg::Q_W];
	fcki_pkg::div_stage_t div_d [fcki_pkg::Q_W];
	fcki_pkg::div_stage_t src;
	logic [fcki_pkg::DR_W-1:0] rr;
	logic                      qb;

	always_comb begin
		src = '0;
		rr  = '0;
		qb  = 1'b0;
		for (int k = 0; k < fcki_pkg::Q_W; k++) begin
			src = (k == 0) ? din : div_s[k-1];
			// first stage takes the integer bit, no shift
			rr  = (k == 0) ? src.r : (src.r << 1);
			qb  = (rr >= fcki_pkg::DR_W'(src.d));
			div_d[k]   = src;
			div_d[k].r = qb ? (rr - fcki_pkg::DR_W'(src.d)) : rr;
			div_d[k].q = {src.q[fcki_pkg::Q_W-2:0], qb};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < fcki_pkg::Q_W; k++) div_s[k].valid <= 1'b0;
		end else if (adv) begin
			for (int k = 0; k < fcki_pkg::Q_W; k++) div_s[k] <= div_d[k];
		end
	end

	assign dout = div_s[fcki_pkg::Q_W-1];

	`FCKI_ASSERT(a_div_rem_below, (!div_s[0].valid || div_s[0].r < fcki_pkg::DR_W'(div_s[0].d)), "divider first stage remainder not below divisor")

endmodule

>>> tb/tb_false_color_key_interpolator_core.sv
// ----------------------------------------------------------------------------
// tb_false_color_key_interpolator_core
// drives samples through the colormap under several key and color settings,
// linear and log mode, and checks every color against a local predictor
// ----------------------------------------------------------------------------
module tb_false_color_key_interpolator_core;
	import fcki_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [31:0]         sample_value;
	logic                out_valid;
	logic                out_ready;
	logic [7:0]          red;
	logic [7:0]          green;
	logic [7:0]          blue;
	logic                math_error;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       err;
	} pixel_t;

	false_color_key_interpolator_core dut (.*);

	// local copy of the register file
	logic        lin_log;
	logic [31:0] key_tab [KEY_COUNT];
	logic [23:0] color_tab [KEY_COUNT];

	pixel_t      pending_colors [$];
	int          mismatch_count;
	longint      cycle_count;

	localparam longint CYCLE_LIMIT = 2_000_000;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic longint log2_fixed(input logic [31:0] v);
		int p;
		logic [63:0] mant;
		longint frac;
		if (v == 32'd0)
			return -longint'(VALUE_FRAC_BITS + 1) * 65536;
		p = 31;
		while (!v[p]) p--;
		mant = 64'(v) << (31 - p);
		frac = 0;
		for (int r = 0; r < 16; r++) begin
			mant = (mant * mant) >> 31;
			frac = frac << 1;
			if (mant >= 64'h1_0000_0000) begin
				frac = frac | 1;
				mant = mant >> 1;
			end
		end
		return longint'(p - VALUE_FRAC_BITS) * 65536 + frac;
	endfunction

	function automatic pixel_t color_of(input logic [31:0] v);
		pixel_t px;
		longint k [KEY_COUNT];
		longint m;
		longint unsigned t;
		longint unsigned a;
		longint unsigned b;
		int seg;
		px = '0;
		if (lin_log && v == 32'd0) begin
			px.err = 1'b1;
			return px;
		end
		for (int i = 0; i < KEY_COUNT; i++)
			k[i] = lin_log ? log2_fixed(key_tab[i]) : longint'(key_tab[i]);
		m = lin_log ? log2_fixed(v) : longint'(v);
		if (m <= k[0]) begin
			seg = 0;
			t = 0;
		end else if (m >= k[KEY_COUNT-1]) begin
			seg = KEY_COUNT - 2;
			t = 65536;
		end else begin
			seg = KEY_COUNT - 1;
			for (int i = 1; i < KEY_COUNT - 1; i++)
				if (seg == KEY_COUNT - 1 && m <= k[i]) seg = i;
			seg--;
			t = (longint'(m - k[seg]) << 16) / longint'(k[seg+1] - k[seg]);
		end
		for (int ch = 0; ch < 3; ch++) begin
			a = (color_tab[seg] >> (16 - 8 * ch)) & 8'hFF;
			b = (color_tab[seg+1] >> (16 - 8 * ch)) & 8'hFF;
			a = ((a * (65536 - t) + b * t) >> 16) & 8'hFF;
			if (ch == 0) px.r = a[7:0];
			else if (ch == 1) px.g = a[7:0];
			else px.b = a[7:0];
		end
		return px;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		mismatch_count++;
	endtask

	// result checker with random backpressure
	initial begin
		int stall;
		pixel_t want;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
			if ($urandom_range(0, 7) < 2) stall = 0;
			out_ready = 1'b0;
			repeat (stall) @(negedge clk);
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_colors.size() == 0) begin
				report_mismatch("unexpected item", {red, green, blue}, 0);
			end else begin
				want = pending_colors.pop_front();
				if (red !== want.r) report_mismatch("red", red, want.r);
				if (green !== want.g) report_mismatch("green", green, want.g);
				if (blue !== want.b) report_mismatch("blue", blue, want.b);
				if (math_error !== want.err)
					report_mismatch("math_error", math_error, want.err);
			end
		end
	end

	// valid stays high into the next item when there is no gap
	task automatic send_sample(input logic [31:0] v);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		sample_value = v;
		do @(posedge clk); while (!in_ready);
		pending_colors.push_back(color_of(v));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending_colors.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_LOG_MODE: lin_log = val[0];
			REG_KEYS_01: begin
				key_tab[0] = val[31:0];
				key_tab[1] = val[63:32];
			end
			REG_KEYS_23: begin
				key_tab[2] = val[31:0];
				key_tab[3] = val[63:32];
			end
			REG_KEY_4: key_tab[4] = val[31:0];
			REG_COLORS_01: begin
				color_tab[0] = val[23:0];
				color_tab[1] = val[47:24];
			end
			REG_COLORS_23: begin
				color_tab[2] = val[23:0];
				color_tab[3] = val[47:24];
			end
			REG_COLOR_4: color_tab[4] = val[23:0];
			default: ;
		endcase
	endtask

	function automatic logic [31:0] random_sample();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 16) << $urandom_range(0, 31);
			3: return key_tab[$urandom_range(0, KEY_COUNT-1)] + $urandom_range(0, 2) - 1;
			default: return $urandom() >> $urandom_range(0, 20);
		endcase
	endfunction

	// keys ascending and spread over a random range, sometimes replaced by unordered random values
	task automatic load_random_map(input logic shuffled);
		logic [31:0] k [KEY_COUNT];
		logic [31:0] step;
		step = $urandom() >> $urandom_range(3, 30);
		k[0] = $urandom() >> $urandom_range(4, 31);
		for (int i = 1; i < KEY_COUNT; i++)
			k[i] = k[i-1] + step + ($urandom() >> $urandom_range(4, 31));
		if (shuffled) begin
			for (int i = 0; i < KEY_COUNT; i++) k[i] = $urandom() >> $urandom_range(0, 16);
		end
		write_reg(REG_KEYS_01, {k[1], k[0]});
		write_reg(REG_KEYS_23, {k[3], k[2]});
		write_reg(REG_KEY_4, {$urandom(), k[4]});
		write_reg(REG_COLORS_01, {$urandom(), $urandom()});
		write_reg(REG_COLORS_23, {$urandom(), $urandom()});
		write_reg(REG_COLOR_4, {$urandom(), $urandom()});
		write_reg(REG_LOG_MODE, {$urandom(), $urandom()});
	endtask

	task automatic test_reset_map();
		logic [31:0] dir [] = '{32'd0, 32'd1, 32'd6553, 32'd6554, 32'd20709, 32'd65536,
			32'd207093, 32'd655359, 32'd655360, 32'd655361, 32'hFFFF_FFFF, 32'h8000_0000,
			32'h0001_8000, 32'h0003_0000, 32'h0000_8000, 32'h5555_5555, 32'hAAAA_AAAA};
		foreach (dir[i]) send_sample(dir[i]);
		wait_drained();
	endtask

	task automatic test_linear_extremes();
		write_reg(REG_LOG_MODE, 64'd0);
		foreach (key_tab[i]) send_sample(key_tab[i]);
		send_sample(32'd0);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'd300000);
		wait_drained();
		// key 0 at zero and the other keys at the top, full white/black colors
		write_reg(REG_KEYS_01, 64'hFFFF_FFFF_0000_0000);
		write_reg(REG_KEYS_23, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_KEY_4, 64'hFFFF_FFFF);
		write_reg(REG_COLORS_01, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_COLORS_23, 64'h0000_0000_0000_0000);
		write_reg(REG_COLOR_4, 64'hFFFF_FFFF);
		send_sample(32'd0);
		send_sample(32'd1);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'hFFFF_FFFE);
		send_sample(32'hFFFF_FFFF);
		wait_drained();
		write_reg(REG_LOG_MODE, 64'd1);
		send_sample(32'd0);
		send_sample(32'd1);
		send_sample(32'hFFFF_FFFF);
		wait_drained();
	endtask

	task automatic test_random_maps();
		for (int phase = 0; phase < 28; phase++) begin
			load_random_map(phase % 5 == 4);
			repeat (50) send_sample(random_sample());
			wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		sample_value = '0;
		mismatch_count = 0;
		cycle_count = 0;
		lin_log = 1'b1;
		key_tab = '{32'd6554, 32'd20724, 32'd65536, 32'd207243, 32'd655360};
		color_tab = '{24'h0000FF, 24'h00FFFF, 24'h00FF00, 24'hFFFF00, 24'hFF0000};
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_reset_map();
		test_linear_extremes();
		test_random_maps();
		wait_drained();
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
